// ===== sv/fsed_pkg.sv =====
`timescale 1ns / 1ps
// fsed_pkg: shared types, register codes and curve table functions for the
// floyd-steinberg error diffusion unit; depends on nothing else
package fsed_pkg;

    localparam int FRAC_BITS = 8;
    localparam int ERR_W     = 18;
    localparam int DEC_DEPTH = 510;

    // full scale, 255 grey steps with the fraction bits below
    localparam logic [15:0] FULL_SCALE = 16'(255 << FRAC_BITS);
    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;

    localparam logic signed [21:0] ERR_HI = 22'sd131071;
    localparam logic signed [21:0] ERR_LO = -22'sd131072;

    // register indexes on the configuration port
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_QUANT_BITS   = 2'd2;
    localparam logic [1:0] REG_GAMMA_MODE   = 2'd3;

    localparam logic [12:0] WIDTH_RST  = 13'd640;
    localparam logic [15:0] HEIGHT_RST = 16'd480;
    localparam logic [3:0]  QBITS_RST  = 4'd1;
    localparam logic        GMODE_RST  = 1'b0;

    typedef logic signed [ERR_W-1:0] err_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_LVL,
        ST_ROM,
        ST_ERR,
        ST_LAST
    } fsed_state_t;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic sum_en;
        logic mul_en;
        logic lvl_en;
        logic rom_en;
        logic commit;
        logic finish_row;
    } fsed_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic out_free;
        logic last_col;
    } fsed_status_t;

    function automatic err_t sat_err(input logic signed [21:0] v);
        if (v > ERR_HI)
            return err_t'(ERR_HI[ERR_W-1:0]);
        else if (v < ERR_LO)
            return err_t'(ERR_LO[ERR_W-1:0]);
        else
            return err_t'(v[ERR_W-1:0]);
    endfunction

    // elaboration-time long division, only used to build the curve tables
    function automatic logic [63:0] udiv_const(input logic [63:0] n, input logic [63:0] m);
        logic [63:0] qt;
        logic [64:0] rm;
        qt = '0;
        rm = '0;
        for (int k = 63; k >= 0; k--) begin
            rm = {rm[63:0], n[k]};
            if (rm >= {1'b0, m}) begin
                rm = rm - {1'b0, m};
                qt[k] = 1'b1;
            end
        end
        return qt;
    endfunction

    function automatic logic [63:0] pow5_q30(input logic [63:0] r);
        logic [63:0] a;
        a = (r * r) >> 30;
        a = (a * r) >> 30;
        a = (a * r) >> 30;
        return (a * r) >> 30;
    endfunction

    // t^2.4 in q30: t^2 times the fifth root of t^2
    function automatic logic [63:0] pow24_q30(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] r;
        logic [63:0] c;
        t2 = (t * t) >> 30;
        r  = '0;
        for (int b = 30; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c <= Q30_ONE) begin
                if (pow5_q30(c) <= t2)
                    r = c;
            end
        end
        return (t2 * r) >> 30;
    endfunction

    // srgb encode curve entry for one 8-bit grey value
    function automatic logic [15:0] enc_srgb(input int unsigned idx);
        logic [63:0] ii;
        logic [63:0] v;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] c;
        ii = 64'(idx);
        if (ii * 64'd10000000 <= 64'd31308 * 64'd255) begin
            v = ((64'd1292 * ii << FRAC_BITS) + 64'd50) / 64'd100;
        end else begin
            x = ((ii << 30) + 64'd127) / 64'd255;
            y = '0;
            for (int b = 30; b >= 0; b--) begin
                c = y | (64'd1 << b);
                if (c <= Q30_ONE) begin
                    if (pow24_q30((c * 64'd1000 + 64'd55 * Q30_ONE) / 64'd1055) <= x)
                        y = c;
                end
            end
            v = ((64'd255 * y << FRAC_BITS) + (64'd1 << 29)) >> 30;
        end
        return v[15:0];
    endfunction

    // level table word: srgb grey [31:24], linear grey [23:16], quantised value [15:0]
    function automatic logic [31:0] dec_word(input int unsigned bq, input int unsigned lv);
        logic [63:0] d;
        logic [63:0] lvl;
        logic [63:0] q;
        logic [63:0] lin;
        logic [63:0] srgb;
        logic [63:0] r;
        d   = (64'd1 << bq) - 64'd1;
        lvl = 64'(lv);
        q   = udiv_const(64'd2 * lvl * 64'(FULL_SCALE) + d, 64'd2 * d);
        lin = udiv_const(64'd255 * lvl, d);
        if (lvl * 64'd100000 < 64'd4045 * d) begin
            srgb = udiv_const(64'd25500 * lvl, 64'd1292 * d);
        end else begin
            r    = pow24_q30(udiv_const((lvl * 64'd1000 + 64'd55 * d) << 30, 64'd1055 * d));
            r    = (64'd255 * r) >> 30;
            srgb = (r > 64'd255) ? 64'd255 : r;
        end
        return {srgb[7:0], lin[7:0], q[15:0]};
    endfunction

endpackage

// ===== sv/fsed_ctrl.sv =====
`timescale 1ns / 1ps
// fsed_ctrl: sequencer for the error diffusion unit, one pixel at a time
// depends on fsed_pkg (state enum, command and status structs)
module fsed_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  fsed_pkg::fsed_status_t st,
    output fsed_pkg::fsed_cmd_t    cmd
);

    fsed_pkg::fsed_state_t state_reg;
    fsed_pkg::fsed_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fsed_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            fsed_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (st.clear_done)
                    state_next = fsed_pkg::ST_IDLE;
            end
            fsed_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = fsed_pkg::ST_SUM;
                end
            end
            fsed_pkg::ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = fsed_pkg::ST_MUL;
            end
            fsed_pkg::ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = fsed_pkg::ST_LVL;
            end
            fsed_pkg::ST_LVL:
            begin
                cmd.lvl_en = 1'b1;
                state_next = fsed_pkg::ST_ROM;
            end
            fsed_pkg::ST_ROM:
            begin
                cmd.rom_en = 1'b1;
                state_next = fsed_pkg::ST_ERR;
            end
            fsed_pkg::ST_ERR:
            begin
                // hold here until the output register can take the result
                if (st.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = st.last_col ? fsed_pkg::ST_LAST : fsed_pkg::ST_IDLE;
                end
            end
            fsed_pkg::ST_LAST:
            begin
                cmd.finish_row = 1'b1;
                state_next     = fsed_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fsed_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== sv/fsed_datapath.sv =====
`timescale 1ns / 1ps
// fsed_datapath: config registers, curve tables, error line store, quantiser
// and error spreading; depends on fsed_pkg
module fsed_datapath #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic [7:0]             pixel_in,
    input  fsed_pkg::fsed_cmd_t    cmd,
    output fsed_pkg::fsed_status_t st,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             pixel_out,
    output logic                   row_end,
    output logic                   frame_end
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [AW-1:0] LAST_COL = AW'(MAX_WIDTH - 1);

    // configuration
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic [3:0]  qbits_reg;
    logic        gmode_reg;

    // position and error carries
    logic [AW-1:0]       col_reg;
    logic [15:0]         row_reg;
    fsed_pkg::err_t      carry_reg;
    fsed_pkg::err_t      pend_reg;
    fsed_pkg::err_t      part_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic                last_row_reg;

    // per pixel stages
    logic [15:0]         enc_reg;
    fsed_pkg::err_t      mem_q_reg;
    logic signed [19:0]  sum_reg;
    logic [15:0]         s_reg;
    logic [15:0]         y_reg;
    logic [7:0]          lvl_reg;
    logic [31:0]         rom_reg;

    logic                out_valid_reg;
    logic [7:0]          out_pix_reg;
    logic                out_row_end_reg;
    logic                out_frame_end_reg;

    fsed_pkg::err_t      store_mem [MAX_WIDTH];

    logic [15:0] enc_tab [256];
    logic [31:0] dec_tab [fsed_pkg::DEC_DEPTH];

    for (genvar gi = 0; gi < 256; gi++)
    begin : g_enc
        localparam logic [15:0] ENC_V = fsed_pkg::enc_srgb(gi);
        assign enc_tab[gi] = ENC_V;
    end

    // level tables for each output depth laid end to end, depth b starts at 2^b - 2
    for (genvar gb = 1; gb <= 8; gb++)
    begin : g_dec_bits
        for (genvar gl = 0; gl < (1 << gb); gl++)
        begin : g_dec_lvl
            localparam logic [31:0] DEC_V = fsed_pkg::dec_word(gb, gl);
            assign dec_tab[(1 << gb) - 2 + gl] = DEC_V;
        end
    end

    // effective settings
    logic [3:0]  qb_c;
    logic [7:0]  d_c;
    logic [8:0]  base_c;
    logic [8:0]  off_c;
    logic [15:0] col_inc_c;
    logic        last_col_c;
    logic        last_row_c;

    always_comb
    begin
        if (qbits_reg == 4'd0)
            qb_c = 4'd1;
        else if (qbits_reg > 4'd8)
            qb_c = 4'd8;
        else
            qb_c = qbits_reg;
        d_c    = 8'((9'd1 << qb_c) - 9'd1);
        base_c = 9'((10'd1 << qb_c) - 10'd2);
        off_c  = base_c + {1'b0, lvl_reg};
    end

    assign col_inc_c  = 16'(col_reg) + 16'd1;
    assign last_col_c = (col_inc_c >= 16'(width_reg)) || (col_reg == LAST_COL);
    assign last_row_c = (17'(row_reg) + 17'd1) >= 17'(height_reg);

    // accumulate and clamp
    logic signed [18:0] err_c;
    logic signed [19:0] sum_c;
    logic [15:0]        s_c;

    always_comb
    begin
        err_c = {carry_reg[17], carry_reg};
        if (row_reg != 16'd0)
            err_c = err_c + {mem_q_reg[17], mem_q_reg};
        sum_c = $signed({4'b0, enc_reg}) + {err_c[18], err_c};
        if (sum_c[19])
            s_c = 16'd0;
        else if (sum_c > $signed({4'b0, fsed_pkg::FULL_SCALE}))
            s_c = fsed_pkg::FULL_SCALE;
        else
            s_c = sum_c[15:0];
    end

    // level = round(s * d / full); full * 2 = 255 << 9
    logic [23:0] prod_c;
    logic [24:0] t_c;
    logic [23:0] yk_c;
    logic [7:0]  q0_c;
    logic [16:0] rem_c;
    logic [7:0]  lvl_c;

    always_comb
    begin
        prod_c = 24'(s_reg) * 24'(d_c);
        t_c    = {prod_c, 1'b0} + {9'b0, fsed_pkg::FULL_SCALE};
        // y / 255 via y * 257 >> 16, low by at most one
        yk_c   = {y_reg, 8'b0} + {8'b0, y_reg};
        q0_c   = yk_c[23:16];
        rem_c  = {1'b0, y_reg} - ({1'b0, q0_c, 8'b0} - {9'b0, q0_c});
        lvl_c  = (rem_c >= 17'd255) ? q0_c + 8'd1 : q0_c;
    end

    // residual and its four shares
    logic signed [20:0] e_c;
    logic signed [24:0] e25_c;
    logic signed [24:0] p3_c;
    logic signed [24:0] p5_c;
    logic signed [24:0] p7_c;
    logic signed [21:0] sh1_c;
    logic signed [21:0] sh3_c;
    logic signed [21:0] sh5_c;
    logic signed [21:0] sh7_c;
    fsed_pkg::err_t     bl_c;
    fsed_pkg::err_t     pend_next_c;
    fsed_pkg::err_t     part_next_c;
    fsed_pkg::err_t     carry_next_c;
    logic [7:0]         pix_c;

    always_comb
    begin
        e_c   = {sum_reg[19], sum_reg} - $signed({5'b0, rom_reg[15:0]});
        e25_c = {{4{e_c[20]}}, e_c};
        p3_c  = (e25_c <<< 1) + e25_c;
        p5_c  = (e25_c <<< 2) + e25_c;
        p7_c  = (e25_c <<< 3) - e25_c;
        // arithmetic shift gives the floor of the sixteenth
        sh1_c = $signed({e25_c[24], e25_c[24:4]});
        sh3_c = $signed({p3_c[24], p3_c[24:4]});
        sh5_c = $signed({p5_c[24], p5_c[24:4]});
        sh7_c = $signed({p7_c[24], p7_c[24:4]});
        bl_c         = fsed_pkg::sat_err({{4{pend_reg[17]}}, pend_reg} + sh3_c);
        pend_next_c  = fsed_pkg::sat_err({{4{part_reg[17]}}, part_reg} + sh5_c);
        part_next_c  = fsed_pkg::sat_err(sh1_c);
        carry_next_c = fsed_pkg::sat_err(sh7_c);
        pix_c = gmode_reg ? rom_reg[23:16] : rom_reg[31:24];
    end

    // error line store, single write port
    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    fsed_pkg::err_t mem_wdata;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = col_reg;
        mem_wdata = bl_c;
        if (cmd.clear_wr)
        begin
            mem_we    = 1'b1;
            mem_addr  = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (cmd.commit && (col_reg != '0))
        begin
            mem_we   = 1'b1;
            mem_addr = col_reg - AW'(1);
        end
        else if (cmd.finish_row)
        begin
            mem_we    = 1'b1;
            mem_wdata = pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_addr] <= mem_wdata;
        if (cmd.accept)
            mem_q_reg <= store_mem[col_reg];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= fsed_pkg::WIDTH_RST;
            height_reg <= fsed_pkg::HEIGHT_RST;
            qbits_reg  <= fsed_pkg::QBITS_RST;
            gmode_reg  <= fsed_pkg::GMODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fsed_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data[12:0];
                fsed_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                fsed_pkg::REG_QUANT_BITS:   qbits_reg  <= cfg_data[3:0];
                fsed_pkg::REG_GAMMA_MODE:   gmode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // position, carries and clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            carry_reg     <= '0;
            pend_reg      <= '0;
            part_reg      <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr && (clr_addr_reg != LAST_COL))
                clr_addr_reg <= clr_addr_reg + AW'(1);
            if (cmd.commit)
            begin
                carry_reg <= carry_next_c;
                pend_reg  <= pend_next_c;
                part_reg  <= part_next_c;
                if (!last_col_c)
                    col_reg <= col_reg + AW'(1);
            end
            if (cmd.finish_row)
            begin
                carry_reg <= '0;
                pend_reg  <= '0;
                part_reg  <= '0;
                col_reg   <= '0;
                row_reg   <= last_row_reg ? 16'd0 : row_reg + 16'd1;
            end
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            enc_reg <= gmode_reg ? {pixel_in, 8'b0} : enc_tab[pixel_in];
        if (cmd.sum_en)
        begin
            sum_reg <= sum_c;
            s_reg   <= s_c;
        end
        if (cmd.mul_en)
            y_reg <= t_c[24:9];
        if (cmd.lvl_en)
            lvl_reg <= lvl_c;
        if (cmd.rom_en)
            rom_reg <= dec_tab[off_c];
        if (cmd.commit)
        begin
            last_row_reg      <= last_row_c;
            out_pix_reg       <= pix_c;
            out_row_end_reg   <= last_col_c;
            out_frame_end_reg <= last_col_c && last_row_c;
        end
    end

    assign st.clear_done = (clr_addr_reg == LAST_COL);
    assign st.out_free   = !out_valid_reg || out_ready;
    assign st.last_col   = last_col_c;

    assign out_valid = out_valid_reg;
    assign pixel_out = out_pix_reg;
    assign row_end   = out_row_end_reg;
    assign frame_end = out_frame_end_reg;

`ifndef SYNTH
    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result committed over an untaken result");

    a_row_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && last_col_c) |=> cmd.finish_row)
        else $error("last column not followed by row finish");

    a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish_row |=> ((col_reg == '0) && (carry_reg == '0) && (part_reg == '0)))
        else $error("row state not restarted");

    a_no_pixel_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (clr_addr_reg == LAST_COL))
        else $error("pixel accepted before the clearing sweep ended");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");
`endif

endmodule

// ===== sv/floyd_steinberg_error_diffusion_unit.sv =====
`timescale 1ns / 1ps
// floyd-steinberg error diffusion unit, 8-bit grey pixel stream in raster order
// input stream s_t*: one pixel per transfer, s_tdata[7:0] = pixel_in
// output stream m_t*: one dithered pixel per input pixel, in the same order;
//   m_tdata[7:0] = pixel_out, m_tlast = last pixel of its row, m_tuser = last of frame
// cfg_*: register writes at any edge with cfg_we high, index 0 frame width,
//   1 frame height, 2 quant bits, 3 gamma mode (0 srgb curves, 1 identity);
//   write only while no pixel is in flight
// sequence: a pixel is registered on transfer, then passes the sum, multiply, level,
//   table and error spread states before m_tvalid rises; the next pixel is taken
//   once it has left error spread; a row end adds a row finish state, as the error
//   line store has a single write port (two writes on a row end)
// reset: a clearing sweep zeroes every entry of the error line store, with
//   s_tready low; registers return to 640 x 480, 1 bit, srgb
// stall: the result waits in an output register while the next pixel is taken
//   and worked on; that pixel then holds before its error spread until
//   m_tready frees the register
// depends on fsed_pkg, fsed_ctrl, fsed_datapath
module floyd_steinberg_error_diffusion_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] pixel_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] pixel_out
    output logic        m_tlast,
    output logic        m_tuser,     // [0] frame_end
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    fsed_pkg::fsed_cmd_t    cmd;
    fsed_pkg::fsed_status_t st;

    fsed_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    fsed_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (s_tdata),
        .cmd       (cmd),
        .st        (st),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .pixel_out (m_tdata),
        .row_end   (m_tlast),
        .frame_end (m_tuser)
    );

endmodule

// ===== sim/floyd_steinberg_error_diffusion_unit_test.sv =====
`timescale 1ns / 1ps
// testbench for the floyd-steinberg error diffusion unit: streams grey pixels under
// random gaps and back-pressure, predicts every dithered pixel in fixed point and
// compares field by field; depends on fsed_pkg and floyd_steinberg_error_diffusion_unit
module floyd_steinberg_error_diffusion_unit_test;

    localparam int              LINE_MAX       = 4096;
    localparam int              FRAC           = 8;
    localparam longint          FULL_GREY      = 255 << FRAC;
    localparam longint unsigned Q30_UNIT       = 64'd1 << 30;
    localparam int              ERR_TOP        = 131071;
    localparam int              ERR_BOTTOM     = -131072;
    localparam int              DIRECTED_ITEMS = 23;
    localparam int              RANDOM_ITEMS   = 600;
    localparam int              HOLD_CYCLES    = 300;
    localparam int              CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic [7:0] grey;
        logic       row_end;
        logic       frame_end;
    } dithered_t;

    class dither_scoreboard;
        int unsigned lift_tab[2][256];
        int          line_err[LINE_MAX];
        int          right_carry;
        int          below_left;
        int          below_right;
        int unsigned col_pos;
        int unsigned row_pos;
        logic [12:0] width_reg;
        logic [15:0] height_reg;
        logic [3:0]  qbits_reg;
        logic        gamma_reg;
        dithered_t   expected_q[$];
        int unsigned mismatches;

        function new();
            for (int i = 0; i < 256; i++)
            begin
                lift_tab[1][i] = i << FRAC;
                lift_tab[0][i] = srgb_lift(i);
            end
            foreach (line_err[k])
                line_err[k] = 0;
            right_carry = 0;
            below_left  = 0;
            below_right = 0;
            col_pos     = 0;
            row_pos     = 0;
            width_reg   = 13'd640;
            height_reg  = 16'd480;
            qbits_reg   = 4'd1;
            gamma_reg   = 1'b0;
            mismatches  = 0;
        endfunction

        function longint unsigned fifth_pow(longint unsigned r);
            longint unsigned a;
            a = r;
            repeat (4)
                a = (a * r) >> 30;
            return a;
        endfunction

        // t^2.4 in q30 as t^2 times the fifth root of t^2, root found bit by bit
        function longint unsigned pow_2p4(longint unsigned t);
            longint unsigned sq;
            longint unsigned root;
            longint unsigned trial;
            sq   = (t * t) >> 30;
            root = 0;
            for (int b = 30; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial <= Q30_UNIT && fifth_pow(trial) <= sq)
                    root = trial;
            end
            return (sq * root) >> 30;
        endfunction

        // encode curve: inverse of the decode power law, searched in q30
        function int unsigned srgb_lift(int unsigned i);
            longint unsigned li;
            longint unsigned target;
            longint unsigned y;
            longint unsigned trial;
            li = i;
            if (li * 64'd10000000 <= 64'd31308 * 64'd255)
                return int'(((64'd1292 * li << FRAC) + 64'd50) / 64'd100);
            target = ((li << 30) + 64'd127) / 64'd255;
            y      = 0;
            for (int b = 30; b >= 0; b--)
            begin
                trial = y | (64'd1 << b);
                if (trial <= Q30_UNIT &&
                    pow_2p4((trial * 64'd1000 + 64'd55 * Q30_UNIT) / 64'd1055) <= target)
                    y = trial;
            end
            return int'(((64'd255 * y << FRAC) + (64'd1 << 29)) >> 30);
        endfunction

        function logic [7:0] level_to_grey(longint unsigned lvl, longint unsigned d, bit lin);
            longint unsigned r;
            if (lin)
                return 8'((64'd255 * lvl) / d);
            if (lvl * 64'd100000 < 64'd4045 * d)
                return 8'((64'd25500 * lvl) / (64'd1292 * d));
            r = pow_2p4(((lvl * 64'd1000 + 64'd55 * d) << 30) / (64'd1055 * d));
            r = (64'd255 * r) >> 30;
            return (r > 64'd255) ? 8'd255 : 8'(r);
        endfunction

        function int clip_err(longint v);
            if (v > ERR_TOP)
                return ERR_TOP;
            if (v < ERR_BOTTOM)
                return ERR_BOTTOM;
            return int'(v);
        endfunction

        // floor of e * w / 16
        function longint spread_share(longint e, longint w);
            return (e * w) >>> 4;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                fsed_pkg::REG_FRAME_WIDTH:  width_reg  = data[12:0];
                fsed_pkg::REG_FRAME_HEIGHT: height_reg = data;
                fsed_pkg::REG_QUANT_BITS:   qbits_reg  = data[3:0];
                fsed_pkg::REG_GAMMA_MODE:   gamma_reg  = data[0];
                default:          ;
            endcase
        endfunction

        function void note_pixel(logic [7:0] pix);
            int unsigned span;
            int unsigned rows;
            int unsigned bits;
            int unsigned x;
            longint      levels;
            longint      acc;
            longint      total;
            longint      clamped;
            longint      lvl;
            longint      qv;
            longint      resid;
            bit          last_col;
            bit          last_row;
            dithered_t   want;
            span = width_reg;
            if (span == 0)
                span = 1;
            else if (span > LINE_MAX)
                span = LINE_MAX;
            rows = (height_reg == 0) ? 1 : height_reg;
            bits = qbits_reg;
            if (bits == 0)
                bits = 1;
            else if (bits > 8)
                bits = 8;
            x        = col_pos;
            levels   = (longint'(1) << bits) - 1;
            last_col = (x + 1 >= span);
            last_row = (row_pos + 1 >= rows);

            // the line store is not read on the first row of a frame
            acc = right_carry;
            if (row_pos > 0)
                acc += line_err[x];
            total = longint'(lift_tab[gamma_reg][pix]) + acc;
            if (total < 0)
                clamped = 0;
            else if (total > FULL_GREY)
                clamped = FULL_GREY;
            else
                clamped = total;
            lvl   = (2 * clamped * levels + FULL_GREY) / (2 * FULL_GREY);
            qv    = (2 * lvl * FULL_GREY + levels) / (2 * levels);
            resid = total - qv;

            want.grey      = level_to_grey(lvl, levels, gamma_reg);
            want.row_end   = last_col;
            want.frame_end = last_col && last_row;

            if (x > 0)
                line_err[x - 1] = clip_err(below_left + spread_share(resid, 3));
            below_left  = clip_err(below_right + spread_share(resid, 5));
            below_right = clip_err(spread_share(resid, 1));
            right_carry = clip_err(spread_share(resid, 7));

            if (last_col)
            begin
                line_err[x] = below_left;
                right_carry = 0;
                below_left  = 0;
                below_right = 0;
                col_pos     = 0;
                row_pos     = last_row ? 0 : row_pos + 1;
            end
            else
            begin
                col_pos = x + 1;
            end
            expected_q.push_back(want);
        endfunction

        function void flag(string field, logic [7:0] want, logic [7:0] got);
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_pixel(logic [7:0] grey, logic row_end, logic frame_end);
            dithered_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: pixel_out expected none, got %0d", $time, grey);
                return;
            end
            want = expected_q.pop_front();
            if (grey !== want.grey)
                flag("pixel_out", want.grey, grey);
            if (row_end !== want.row_end)
                flag("row_end", 8'(want.row_end), 8'(row_end));
            if (frame_end !== want.frame_end)
                flag("frame_end", 8'(want.frame_end), 8'(frame_end));
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    dither_scoreboard sb;
    int unsigned      pixels_sent;
    int unsigned      pixels_back;
    bit               hold_request;
    bit               hold_served;
    logic [7:0]       burst[$];

    floyd_steinberg_error_diffusion_unit #(
        .MAX_WIDTH (LINE_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // offers one pixel, sometimes after a short gap, and waits for its transfer
    task automatic send_pixel(input logic [7:0] grey);
        if (!(pixels_sent >= 250 && pixels_sent < 400) && $urandom_range(99) < 22)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= grey;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        sb.note_pixel(grey);
        pixels_sent++;
    endtask

    task automatic send_burst();
        foreach (burst[k])
            send_pixel(burst[k]);
        s_tvalid <= 1'b0;
    endtask

    // leaves cfg_we high; the caller lowers it after the last write
    task automatic write_one(input logic [1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_settings(input logic [15:0] w, input logic [15:0] h,
                                  input logic [15:0] qb, input logic [15:0] gm);
        write_one(fsed_pkg::REG_FRAME_WIDTH, w);
        write_one(fsed_pkg::REG_FRAME_HEIGHT, h);
        write_one(fsed_pkg::REG_QUANT_BITS, qb);
        write_one(fsed_pkg::REG_GAMMA_MODE, gm);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                sb.check_pixel(m_tdata, m_tlast, m_tuser);
                pixels_back++;
            end
            if (hold_request && !hold_served)
            begin
                hold_left   = HOLD_CYCLES;
                hold_served = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= (pixels_back >= 250 && pixels_back < 400) ||
                            ($urandom_range(99) >= 22);
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int          phase;
        int          n;
        int          style;
        int          pick;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] qb;
        logic [15:0] gm;
        logic [7:0]  base;
        logic [7:0]  step;
        logic [7:0]  grey;
        sb           = new();
        pixels_sent  = 0;
        pixels_back  = 0;
        hold_request = 1'b0;
        hold_served  = 1'b0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        cfg_we    <= 1'b0;
        cfg_index <= fsed_pkg::REG_FRAME_WIDTH;
        cfg_data  <= 16'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, first row of a frame
        burst = {8'd0, 8'd255, 8'd128, 8'd1};
        send_burst();
        // zero width, height and quant bits act as one; column left past the new edge
        settle();
        apply_settings(16'd0, 16'd0, 16'd0, 16'd1);
        burst = {8'd0, 8'd255, 8'd77};
        send_burst();
        // tiny full frame with quant bits above eight
        settle();
        apply_settings(16'd3, 16'd2, 16'd15, 16'd0);
        burst = {8'd255, 8'd0, 8'd200, 8'd13, 8'd255, 8'd0};
        send_burst();
        // width beyond the line store, tallest frame, eight bits
        settle();
        apply_settings(16'd8191, 16'd65535, 16'd8, 16'd1);
        burst = {8'd1, 8'd254, 8'd128, 8'd127};
        send_burst();
        // column again past the edge, then rows that read the stored error
        settle();
        apply_settings(16'd2, 16'd3, 16'd9, 16'd0);
        burst = {8'd255, 8'd255, 8'd0, 8'd0, 8'd170, 8'd85};
        send_burst();

        phase = 0;
        while (pixels_sent < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            settle();
            pick = $urandom_range(99);
            if (pick < 70)
                w = 16'($urandom_range(12, 1));
            else if (pick < 85)
                w = 16'($urandom_range(64, 13));
            else if (pick < 95)
                w = ($urandom_range(1) != 0) ? 16'd0 : 16'd4096;
            else
                w = 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 70)
                h = 16'($urandom_range(5, 1));
            else if (pick < 80)
                h = 16'd0;
            else if (pick < 92)
                h = 16'($urandom_range(40, 6));
            else
                h = 16'($urandom);
            if ($urandom_range(99) < 80)
                qb = {12'($urandom), 4'($urandom_range(8, 1))};
            else
                qb = 16'($urandom);
            gm = 16'($urandom);
            apply_settings(w, h, qb, gm);

            n     = $urandom_range(60, 15);
            style = $urandom_range(3);
            base  = 8'($urandom);
            step  = 8'($urandom_range(9, 1));
            // one phase runs into a long output stall so the input side backs up
            if (phase == 2)
            begin
                n            = 40;
                hold_request = 1'b1;
            end
            for (int i = 0; i < n; i++)
            begin
                case (style)
                    0:       grey = 8'($urandom);
                    1:       grey = ($urandom_range(7) == 0) ? 8'($urandom) : base;
                    2:       grey = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
                    default: grey = 8'(base + 8'(i) * step);
                endcase
                send_pixel(grey);
            end
            s_tvalid <= 1'b0;
            phase++;
        end

        settle();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
